### sv/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg: shared definitions for the sparse CPU set table
// Sizes of the bucket table, function codes and the types passed between the
// sequencer and the bucket unit.
// ----------------------------------------------------------------------------
package scs_pkg;

    localparam int BUCKETS     = 16;
    localparam int CPU_ID_BITS = 10;

    localparam int FUNC_W  = 3;
    localparam int LOW_W   = 3;
    localparam int MASK_W  = 1 << LOW_W;
    localparam int TAG_W   = CPU_ID_BITS - LOW_W;
    localparam int IDX_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int USED_W  = $clog2(BUCKETS + 1);
    localparam int COUNT_W = 8;
    localparam int ENTRY_W = TAG_W + MASK_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [FUNC_W-1:0] FN_SET   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd1;
    localparam logic [FUNC_W-1:0] FN_TEST  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_COUNT = 3'd3;
    localparam logic [FUNC_W-1:0] FN_RESET = 3'd4;

    typedef struct packed {
        logic               count_op;
        logic [TAG_W-1:0]   tag;
        logic [TAG_W-1:0]   ent_tag;
        logic [MASK_W-1:0]  ent_bits;
        logic [COUNT_W-1:0] acc;
    } t_unit_in;

    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] acc;
    } t_unit_out;

endpackage

### sv/scs_ram.sv
// ----------------------------------------------------------------------------
// scs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module scs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/scs_unit.sv
// ----------------------------------------------------------------------------
// scs_unit: shared bucket unit
// For a search it compares a bucket tag against the search tag; for a count it
// adds the bucket's population count to a saturating accumulator.
// ----------------------------------------------------------------------------
module scs_unit
    import scs_pkg::*;
(
    input  t_unit_in  i_req,
    output t_unit_out o_rsp
);

    logic [COUNT_W-1:0] pop;
    logic [COUNT_W:0]   sum;

    always_comb begin
        pop = '0;
        for (int i = 0; i < MASK_W; i++) begin
            pop = pop + COUNT_W'(i_req.ent_bits[i]);
        end
        sum = {1'b0, i_req.acc} + {1'b0, pop};
    end

    always_comb begin
        o_rsp.hit = !i_req.count_op && (i_req.ent_tag == i_req.tag);
        if (!i_req.count_op) begin
            o_rsp.acc = i_req.acc;
        end else if (sum[COUNT_W]) begin
            o_rsp.acc = COUNT_MAX;
        end else begin
            o_rsp.acc = sum[COUNT_W-1:0];
        end
    end

endmodule

### sv/sparse_cpu_set_table.sv
// ----------------------------------------------------------------------------
// sparse_cpu_set_table: sparse set of CPU numbers kept in a bucket table
// Each bucket holds a tag (CPU number without its low three bits) and an
// eight-bit membership mask. Supports set, clear, test, count and reset.
// ----------------------------------------------------------------------------
// Usage:
// Commands enter on i_valid/o_ready with i_func and i_cpu_id; each command
// gives exactly one result transaction on o_valid/i_ready carrying
// o_is_member, o_member_count and o_status.
// Set, clear, test and count walk the used buckets (at most BUCKETS) through one
// RAM read port and one shared compare/popcount unit, one bucket per cycle,
// then pass through S_FIN to S_OUT; a find stops at the first matching bucket.
// Reset-table and unused codes go from S_IDLE straight to S_OUT.
// The block accepts one command at a time; o_ready is high only while idle.
// A finished result sits in the output register; the next command may be
// accepted while it waits, and its own result holds until the register frees.
// A set that needs a new bucket while the table is full is dropped with
// o_status = 1. After i_rst_n the table is empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sparse_cpu_set_table
    import scs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [FUNC_W-1:0]      i_func,
    input  logic [CPU_ID_BITS-1:0] i_cpu_id,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_is_member,
    output logic [COUNT_W-1:0]     o_member_count,
    output logic                   o_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FIN,
        S_OUT
    } t_state;

    t_state r_state, n_state;

    logic [FUNC_W-1:0]      r_func, n_func;
    logic [CPU_ID_BITS-1:0] r_cpu, n_cpu;
    logic [USED_W-1:0]      r_used, n_used;
    logic [USED_W-1:0]      r_idx, n_idx;
    logic                   r_pend, n_pend;
    logic [IDX_W-1:0]       r_pidx, n_pidx;
    logic                   r_found, n_found;
    logic [IDX_W-1:0]       r_fidx, n_fidx;
    logic [MASK_W-1:0]      r_fbits, n_fbits;
    logic [COUNT_W-1:0]     r_acc, n_acc;
    logic                   r_res_mem, n_res_mem;
    logic [COUNT_W-1:0]     r_res_cnt, n_res_cnt;
    logic                   r_res_st, n_res_st;
    logic                   r_o_valid, n_o_valid;
    logic                   r_o_mem, n_o_mem;
    logic [COUNT_W-1:0]     r_o_cnt, n_o_cnt;
    logic                   r_o_st, n_o_st;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic                   ram_re;
    logic [ENTRY_W-1:0]     ram_rdata;

    logic [TAG_W-1:0]       cur_tag;
    logic [MASK_W-1:0]      cur_bit;
    t_unit_in               unit_req;
    t_unit_out              unit_rsp;

    assign cur_tag = r_cpu[CPU_ID_BITS-1:LOW_W];
    assign cur_bit = MASK_W'(1) << r_cpu[LOW_W-1:0];

    scs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BUCKETS),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        unit_req.count_op = (r_func == FN_COUNT);
        unit_req.tag      = cur_tag;
        unit_req.ent_tag  = ram_rdata[ENTRY_W-1:MASK_W];
        unit_req.ent_bits = ram_rdata[MASK_W-1:0];
        unit_req.acc      = r_acc;
    end

    scs_unit u_unit (
        .i_req (unit_req),
        .o_rsp (unit_rsp)
    );

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_cpu     = r_cpu;
        n_used    = r_used;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_pidx    = r_pidx;
        n_found   = r_found;
        n_fidx    = r_fidx;
        n_fbits   = r_fbits;
        n_acc     = r_acc;
        n_res_mem = r_res_mem;
        n_res_cnt = r_res_cnt;
        n_res_st  = r_res_st;
        n_o_valid = r_o_valid;
        n_o_mem   = r_o_mem;
        n_o_cnt   = r_o_cnt;
        n_o_st    = r_o_st;
        ram_we    = 1'b0;
        ram_waddr = r_fidx;
        ram_wdata = {cur_tag, r_fbits | cur_bit};
        ram_re    = 1'b0;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_func    = i_func;
                    n_cpu     = i_cpu_id;
                    n_idx     = '0;
                    n_pend    = 1'b0;
                    n_found   = 1'b0;
                    n_acc     = '0;
                    n_res_mem = 1'b0;
                    n_res_cnt = '0;
                    n_res_st  = 1'b0;
                    if (i_func == FN_SET || i_func == FN_CLEAR ||
                        i_func == FN_TEST || i_func == FN_COUNT) begin
                        n_state = S_WALK;
                    end else begin
                        if (i_func == FN_RESET) begin
                            n_used = '0;
                        end
                        n_state = S_OUT;
                    end
                end
            end
            S_WALK: begin
                // The read issued last cycle is checked while the next one goes out.
                if (r_pend) begin
                    n_acc = unit_rsp.acc;
                end
                if (r_pend && unit_rsp.hit) begin
                    n_found = 1'b1;
                    n_fidx  = r_pidx;
                    n_fbits = ram_rdata[MASK_W-1:0];
                    n_pend  = 1'b0;
                    n_state = S_FIN;
                end else if (r_idx == r_used) begin
                    n_pend  = 1'b0;
                    n_state = S_FIN;
                end else begin
                    ram_re = 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_idx[IDX_W-1:0];
                    n_idx  = r_idx + USED_W'(1);
                end
            end
            S_FIN: begin
                case (r_func)
                    FN_SET: begin
                        if (r_found) begin
                            ram_we = 1'b1;
                        end else if (r_used < USED_W'(BUCKETS)) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_used[IDX_W-1:0];
                            ram_wdata = {cur_tag, cur_bit};
                            n_used    = r_used + USED_W'(1);
                        end else begin
                            n_res_st = 1'b1;
                        end
                    end
                    FN_CLEAR: begin
                        if (r_found) begin
                            ram_we    = 1'b1;
                            ram_wdata = {cur_tag, r_fbits & ~cur_bit};
                        end
                    end
                    FN_TEST: begin
                        n_res_mem = r_found && ((r_fbits & cur_bit) != '0);
                    end
                    FN_COUNT: begin
                        n_res_cnt = r_acc;
                    end
                    default: begin
                    end
                endcase
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_mem   = r_res_mem;
                    n_o_cnt   = r_res_cnt;
                    n_o_st    = r_res_st;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
        end
        r_func    <= n_func;
        r_cpu     <= n_cpu;
        r_idx     <= n_idx;
        r_pidx    <= n_pidx;
        r_found   <= n_found;
        r_fidx    <= n_fidx;
        r_fbits   <= n_fbits;
        r_acc     <= n_acc;
        r_res_mem <= n_res_mem;
        r_res_cnt <= n_res_cnt;
        r_res_st  <= n_res_st;
        r_o_mem   <= n_o_mem;
        r_o_cnt   <= n_o_cnt;
        r_o_st    <= n_o_st;
    end

    assign o_valid        = r_o_valid;
    assign o_is_member    = r_o_mem;
    assign o_member_count = r_o_cnt;
    assign o_status       = r_o_st;

    // The bucket count never passes the table size.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(BUCKETS))
        else $error("bucket count exceeds table size");

    // A dropped set is only reported when the table is full.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_res_st) |-> (r_used == USED_W'(BUCKETS)))
        else $error("set dropped while buckets remain");

    // A result carries at most one kind of answer.
    a_one_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_member && (o_member_count != '0)) &&
                    !(o_status && (o_is_member || (o_member_count != '0))))
        else $error("result mixes answers of different commands");

    // An accepted command always leaves the idle state.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("accepted command did not start");

endmodule

### sim/sparse_cpu_set_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_cpu_set_table_tb: self-checking testbench for the sparse CPU set table
// Commands go in through a bursty sender. A local bucket-table predictor
// computes the result of every accepted command. The result port is stalled
// on a pattern of its own, and each result transaction is compared field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module sparse_cpu_set_table_tb;
    import scs_pkg::*;

    // Function codes that the block treats as no operation.
    localparam logic [FUNC_W-1:0] FN_SPARE5 = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE7 = 3'd7;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TIME  = 40;
    localparam int RANDOM_ITEMS = 640;

    typedef struct {
        logic               is_member;
        logic [COUNT_W-1:0] member_count;
        logic               status;
    } t_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [FUNC_W-1:0]      i_func = FN_TEST;
    logic [CPU_ID_BITS-1:0] i_cpu_id = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic                   o_is_member;
    logic [COUNT_W-1:0]     o_member_count;
    logic                   o_status;

    // Predictor state: a copy of the bucket table.
    logic [TAG_W-1:0]  tbl_tag [BUCKETS];
    logic [MASK_W-1:0] tbl_mask[BUCKETS];
    int                tbl_used = 0;

    t_result pending_results[$];
    t_result head_result;
    t_result seen_result;
    int      mismatch_count = 0;
    int      cycle_count = 0;
    int      burst_left = 0;
    int      rx_cycle = 0;
    int      rx_mode = 0;
    logic [7:0] rx_pattern = 8'hA5;

    sparse_cpu_set_table i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_cpu_id       (i_cpu_id),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_is_member    (o_is_member),
        .o_member_count (o_member_count),
        .o_status       (o_status)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Applies one command to the local table and returns its result.
    function automatic t_result apply_command(input logic [FUNC_W-1:0] fn,
                                              input logic [CPU_ID_BITS-1:0] cpu);
        t_result          res;
        logic [TAG_W-1:0] tag;
        logic [LOW_W-1:0] low;
        int               hit;
        int               total;
        res = '{is_member: 1'b0, member_count: '0, status: 1'b0};
        tag = cpu[CPU_ID_BITS-1:LOW_W];
        low = cpu[LOW_W-1:0];
        hit = -1;
        total = 0;
        for (int b = 0; b < tbl_used; b++) begin
            if (hit < 0 && tbl_tag[b] == tag)
                hit = b;
        end
        case (fn)
            FN_SET: begin
                if (hit >= 0) begin
                    tbl_mask[hit][low] = 1'b1;
                end else if (tbl_used < BUCKETS) begin
                    tbl_tag[tbl_used]       = tag;
                    tbl_mask[tbl_used]      = '0;
                    tbl_mask[tbl_used][low] = 1'b1;
                    tbl_used++;
                end else begin
                    res.status = 1'b1;
                end
            end
            FN_CLEAR: begin
                if (hit >= 0)
                    tbl_mask[hit][low] = 1'b0;
            end
            FN_TEST: begin
                if (hit >= 0)
                    res.is_member = tbl_mask[hit][low];
            end
            FN_COUNT: begin
                for (int b = 0; b < tbl_used; b++)
                    total += $countones(tbl_mask[b]);
                res.member_count = (total > COUNT_MAX) ? COUNT_MAX : total[COUNT_W-1:0];
            end
            FN_RESET: begin
                tbl_used = 0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input t_result want, input t_result got,
                                   input bit orphan);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            if (orphan)
                $display("unexpected result at cycle %0d: member=%0d count=%0d status=%0d",
                         cycle_count, got.is_member, got.member_count, got.status);
            else
                $display({"result differs at cycle %0d: ",
                          "expected member=%0d count=%0d status=%0d, ",
                          "got member=%0d count=%0d status=%0d"},
                         cycle_count, want.is_member, want.member_count, want.status,
                         got.is_member, got.member_count, got.status);
        end
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen_result = '{is_member: o_is_member, member_count: o_member_count,
                            status: o_status};
            if (pending_results.size() == 0) begin
                report_mismatch(seen_result, seen_result, 1'b1);
            end else begin
                head_result = pending_results.pop_front();
                if (seen_result.is_member !== head_result.is_member ||
                    seen_result.member_count !== head_result.member_count ||
                    seen_result.status !== head_result.status)
                    report_mismatch(head_result, seen_result, 1'b0);
            end
        end
    end

    // The receiver switches between always ready, random stalls and a fixed
    // bit pattern every so often.
    always @(posedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 97 == 0) begin
            rx_mode    = $urandom_range(0, 3);
            rx_pattern = 8'($urandom_range(0, 255)) | 8'h01;
        end
        case (rx_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 3) != 0);
            2: i_ready <= rx_pattern[rx_cycle % 8];
            default: i_ready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Between bursts the sender drops valid for a random gap.
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(0, 10);
        end
    endtask

    task automatic send_item(input logic [FUNC_W-1:0] fn,
                             input logic [CPU_ID_BITS-1:0] cpu);
        i_valid  <= 1'b1;
        i_func   <= fn;
        i_cpu_id <= cpu;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(apply_command(fn, cpu));
        pace_sender();
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Extremes, every function, a full table and the no-effect cases.
    task automatic test_directed_cases();
        logic [CPU_ID_BITS-1:0] cpu;
        send_item(FN_SET, 10'd0);
        send_item(FN_SET, 10'd1023);
        for (int t = 1; t <= 14; t++) begin
            cpu = {t[TAG_W-1:0], t[LOW_W-1:0]};
            send_item(FN_SET, cpu);
        end
        // Table is full: a new tag is dropped, an existing tag still works.
        send_item(FN_SET, {7'd64, 3'd3});
        send_item(FN_SET, 10'd0);
        send_item(FN_TEST, 10'd1023);
        send_item(FN_TEST, {7'd64, 3'd3});
        send_item(FN_CLEAR, 10'd1023);
        send_item(FN_CLEAR, {7'd64, 3'd3});
        send_item(FN_CLEAR, 10'd1);
        send_item(FN_COUNT, 10'd0);
        send_item(FN_SPARE5, 10'd1023);
        send_item(FN_SPARE6, 10'd1023);
        send_item(FN_SPARE7, 10'd1023);
        send_item(FN_RESET, 10'd1023);
        send_item(FN_COUNT, 10'd1023);
        send_item(FN_TEST, 10'd0);
    endtask

    // Every bit of sixteen buckets is set, so the count reaches 128, below its saturation limit.
    task automatic test_full_table_count();
        bit [127:0]             taken;
        logic [TAG_W-1:0]       tags[BUCKETS];
        logic [CPU_ID_BITS-1:0] ids[BUCKETS*MASK_W];
        logic [CPU_ID_BITS-1:0] swap;
        int                     pick;
        taken = '0;
        for (int i = 0; i < BUCKETS; i++) begin
            do pick = $urandom_range(0, 127); while (taken[pick]);
            taken[pick] = 1'b1;
            tags[i] = pick[TAG_W-1:0];
        end
        for (int i = 0; i < BUCKETS * MASK_W; i++)
            ids[i] = {tags[i / MASK_W], i[LOW_W-1:0]};
        for (int i = BUCKETS * MASK_W - 1; i > 0; i--) begin
            pick = $urandom_range(0, i);
            swap = ids[i];
            ids[i] = ids[pick];
            ids[pick] = swap;
        end
        send_item(FN_RESET, CPU_ID_BITS'($urandom_range(0, 1023)));
        for (int i = 0; i < BUCKETS * MASK_W; i++) begin
            send_item(FN_SET, ids[i]);
            if (i % 32 == 31)
                send_item(FN_COUNT, CPU_ID_BITS'($urandom_range(0, 1023)));
        end
        send_item(FN_COUNT, CPU_ID_BITS'($urandom_range(0, 1023)));
        send_item(FN_TEST, ids[$urandom_range(0, BUCKETS * MASK_W - 1)]);
        send_item(FN_CLEAR, ids[0]);
        send_item(FN_COUNT, CPU_ID_BITS'($urandom_range(0, 1023)));
    endtask

    // Random traffic on small pools of tags, so buckets are hit again and the
    // table fills; a tenth of the CPU numbers are fully random.
    task automatic test_random_traffic();
        logic [TAG_W-1:0]       pool[24];
        logic [CPU_ID_BITS-1:0] cpu;
        logic [FUNC_W-1:0]      fn;
        int                     pool_size;
        int                     epoch_len;
        int                     roll;
        int                     sent;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0: pool_size = 2;
                1: pool_size = 8;
                2: pool_size = 16;
                default: pool_size = 24;
            endcase
            for (int i = 0; i < pool_size; i++)
                pool[i] = TAG_W'($urandom_range(0, 127));
            if ($urandom_range(0, 2) == 0) begin
                send_item(FN_RESET, CPU_ID_BITS'($urandom_range(0, 1023)));
                sent++;
            end
            epoch_len = $urandom_range(40, 90);
            for (int n = 0; n < epoch_len; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 38)      fn = FN_SET;
                else if (roll < 58) fn = FN_CLEAR;
                else if (roll < 84) fn = FN_TEST;
                else if (roll < 95) fn = FN_COUNT;
                else if (roll < 97) fn = FN_RESET;
                else                fn = FUNC_W'($urandom_range(FN_SPARE5, FN_SPARE7));
                if ($urandom_range(0, 9) == 0)
                    cpu = CPU_ID_BITS'($urandom_range(0, 1023));
                else
                    cpu = {pool[$urandom_range(0, pool_size - 1)],
                           3'($urandom_range(0, 7))};
                send_item(fn, cpu);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        wait_for_results();
        test_full_table_count();
        wait_for_results();
        test_random_traffic();
        wait_for_results();
        repeat (SETTLE_TIME) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
sv/scs_pkg.sv
sv/scs_ram.sv
sv/scs_unit.sv
sv/sparse_cpu_set_table.sv
sim/sparse_cpu_set_table_tb.sv
